### rtl/core/cdnc_pkg.sv
package cdnc_pkg;

	// Largest accepted year magnitude.
	localparam int MAX_YEAR = 32767;

	// Q0.32 reciprocals of the mean year length.
	localparam logic [23:0] RECIP_GREG = 24'd11759221;
	localparam logic [23:0] RECIP_JUL  = 24'd11758980;

	// Operation select codes.
	typedef enum logic [1:0] {
		FUNC_DATE_TO_NUM = 2'd0,
		FUNC_NUM_TO_DATE = 2'd1,
		FUNC_ISO_WEEK    = 2'd2,
		FUNC_NONE        = 2'd3
	} func_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_YEAR  = 2'd1,
		ERR_MONTH = 2'd2,
		ERR_DAY   = 2'd3
	} err_t;

	// Days before the first of month idx+1; idx 12 gives the year length.
	function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] idx);
		logic [8:0] base;
		case (idx)
			4'd0:    base = 9'd0;
			4'd1:    base = 9'd31;
			4'd2:    base = 9'd59;
			4'd3:    base = 9'd90;
			4'd4:    base = 9'd120;
			4'd5:    base = 9'd151;
			4'd6:    base = 9'd181;
			4'd7:    base = 9'd212;
			4'd8:    base = 9'd243;
			4'd9:    base = 9'd273;
			4'd10:   base = 9'd304;
			4'd11:   base = 9'd334;
			4'd12:   base = 9'd365;
			default: base = 9'd0;
		endcase
		return base + ((leap && (idx >= 4'd2)) ? 9'd1 : 9'd0);
	endfunction

	// Length of month idx+1.
	function automatic logic [4:0] month_len(input logic leap, input logic [3:0] idx);
		logic [4:0] len;
		case (idx)
			4'd1:                       len = leap ? 5'd29 : 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10:    len = 5'd30;
			4'd0, 4'd2, 4'd4, 4'd6,
			4'd7, 4'd9, 4'd11:          len = 5'd31;
			default:                    len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

### rtl/core/cdnc_month_find.sv
module cdnc_month_find (
	input  logic [8:0] yday,
	input  logic       leap,
	output logic [3:0] month,
	output logic [4:0] day
);
	import cdnc_pkg::*;

	logic [3:0] count;

	// Count the month starts that lie before the day of year.
	always_comb begin
		count = 4'd0;
		for (int k = 1; k < 12; k++) begin
			if (cum_days(leap, 4'(k)) < yday) begin
				count = count + 4'd1;
			end
		end
	end

	// Month is one past the count; day is the rest within that month.
	assign month = count + 4'd1;
	assign day   = 5'(yday - cum_days(leap, count));

endmodule

### rtl/core/calendar_day_number_converter.sv
// Calendar day-number converter.
// Requests enter on in_valid/in_stall with func, year_in, month_in, day_in and
// day_number_in; a request is taken on a clock edge with in_valid high and
// in_stall low. Results leave on out_valid/out_stall, one result per request,
// in request order. func 0 turns a date into a day number, func 1 turns a day
// number into a date, func 2 gives the ISO week of a date; func 3 yields zeros.
// calendar_mode is written through cfg_valid/cfg_ready/cfg_data (ready is
// always high) and is sampled with each request as it enters.
// The datapath is an eight-stage pipeline: one request can enter every cycle
// while the output does not stall. The stages hold the year-estimate multiplier,
// the divide by 100 and its correction, the year start sum, the year correction,
// the mod-7 multiplier, the weekday and the ISO week.
// Each stage advances when it is empty or the stage after it advances, so a
// stall at the output fills bubbles first and then holds every stage; in_stall
// rises only when the first stage is full and cannot move.
// Reset clears all valid bits and selects the Gregorian calendar.
module calendar_day_number_converter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic signed [15:0] year_in,
	input  logic signed [4:0]  month_in,
	input  logic signed [5:0]  day_in,
	input  logic signed [24:0] day_number_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [24:0] day_number_out,
	output logic signed [15:0] year_out,
	output logic [3:0]         month_out,
	output logic [4:0]         day_out,
	output logic [8:0]         day_of_year_out,
	output logic [2:0]         weekday_out,
	output logic [5:0]         iso_week_out,
	output logic [1:0]         error_code,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data
);
	import cdnc_pkg::*;

	localparam logic signed [16:0] YEAR_HI = 17'(MAX_YEAR);
	localparam logic signed [16:0] YEAR_LO = -17'(MAX_YEAR);

	// Configuration register.
	logic calendar_mode_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calendar_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			calendar_mode_q <= cfg_data;
		end
	end

	// Valid bits and stage enables.
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7, valid_s8;
	logic en1, en2, en3, en4, en5, en6, en7, en8;

	assign en8 = !valid_s8 || !out_stall;
	assign en7 = !valid_s7 || en8;
	assign en6 = !valid_s6 || en7;
	assign en5 = !valid_s5 || en6;
	assign en4 = !valid_s4 || en5;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= in_valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
			if (en5) valid_s5 <= valid_s4;
			if (en6) valid_s6 <= valid_s5;
			if (en7) valid_s7 <= valid_s6;
			if (en8) valid_s8 <= valid_s7;
		end
	end

	// Stage 1: capture the request and multiply |day number| by the reciprocal.
	logic [24:0] mag_c;
	logic [23:0] recip_c;
	logic [47:0] prod_c;

	assign mag_c   = day_number_in[24] ? (~$unsigned(day_number_in) + 25'd1)
	                                   : $unsigned(day_number_in);
	assign recip_c = calendar_mode_q ? RECIP_JUL : RECIP_GREG;
	assign prod_c  = 48'(mag_c) * 48'(recip_c);

	func_t              func_s1;
	logic               mode_s1;
	logic signed [15:0] year_s1;
	logic signed [4:0]  month_s1;
	logic signed [5:0]  day_s1;
	logic signed [24:0] dn_s1;
	logic [47:0]        prod_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			func_s1  <= func_t'(func);
			mode_s1  <= calendar_mode_q;
			year_s1  <= year_in;
			month_s1 <= month_in;
			day_s1   <= day_in;
			dn_s1    <= day_number_in;
			prod_s1  <= prod_c;
		end
	end

	// Stage 2: pick the working year and start the divide by 100 of year - 1.
	logic [15:0]        est_c;
	logic signed [16:0] yr2_c;
	logic signed [17:0] a2_c;
	logic [16:0]        u2_c;
	logic [29:0]        p100_c;

	assign est_c = prod_s1[47:32];

	always_comb begin
		if (func_s1 == FUNC_NUM_TO_DATE) begin
			if (dn_s1[24]) begin
				yr2_c = -$signed({1'b0, est_c});
			end else if (dn_s1 == 25'sd0) begin
				yr2_c = 17'sd0;
			end else begin
				yr2_c = $signed({1'b0, est_c}) + 17'sd1;
			end
		end else begin
			yr2_c = {year_s1[15], year_s1};
		end
	end

	assign a2_c   = {yr2_c[16], yr2_c} - 18'sd1;
	assign u2_c   = 17'($unsigned(a2_c + 18'sd50000));
	assign p100_c = 30'(u2_c) * 30'd5243;

	func_t              func_s2;
	logic               mode_s2;
	logic signed [4:0]  month_s2;
	logic signed [5:0]  day_s2;
	logic signed [24:0] dn_s2;
	logic signed [17:0] a_s2;
	logic [16:0]        u_s2;
	logic [29:0]        p100_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			func_s2  <= func_s1;
			mode_s2  <= mode_s1;
			month_s2 <= month_s1;
			day_s2   <= day_s1;
			dn_s2    <= dn_s1;
			a_s2     <= a2_c;
			u_s2     <= u2_c;
			p100_s2  <= p100_c;
		end
	end

	// Stage 3: correct the quotient and form the remainders by 100 and 400.
	logic [10:0]        q3_c;
	logic [17:0]        q3x100_c;
	logic signed [17:0] rem3_c;
	logic [10:0]        qf3_c;
	logic [6:0]         r100_c;
	logic signed [11:0] q100_c;
	logic [8:0]         r400_c;

	assign q3_c     = p100_s2[29:19];
	assign q3x100_c = 18'(q3_c) * 18'd100;
	assign rem3_c   = $signed({1'b0, u_s2}) - $signed(q3x100_c);
	assign qf3_c    = rem3_c[17] ? (q3_c - 11'd1) : q3_c;
	assign r100_c   = rem3_c[17] ? 7'(rem3_c + 18'sd100) : 7'(rem3_c);
	assign q100_c   = $signed({1'b0, qf3_c}) - 12'sd500;
	assign r400_c   = 9'(q100_c[1:0]) * 9'd100 + 9'(r100_c);

	func_t              func_s3;
	logic               mode_s3;
	logic signed [4:0]  month_s3;
	logic signed [5:0]  day_s3;
	logic signed [24:0] dn_s3;
	logic signed [17:0] a_s3;
	logic signed [11:0] q100_s3;
	logic [6:0]         r100_s3;
	logic [8:0]         r400_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			func_s3  <= func_s2;
			mode_s3  <= mode_s2;
			month_s3 <= month_s2;
			day_s3   <= day_s2;
			dn_s3    <= dn_s2;
			a_s3     <= a_s2;
			q100_s3  <= q100_c;
			r100_s3  <= r100_c;
			r400_s3  <= r400_c;
		end
	end

	// Stage 4: day number of the day before the year starts, and leap flags
	// of the year before, the year itself and the year after.
	logic signed [26:0] ax_c, a365_c, q4_c, qh_c, qf_c, ys4_c;
	logic [2:0]         leap4_c;

	assign ax_c   = {{9{a_s3[17]}}, a_s3};
	assign a365_c = (ax_c <<< 8) + (ax_c <<< 6) + (ax_c <<< 5) + (ax_c <<< 3)
	              + (ax_c <<< 2) + ax_c;
	assign q4_c   = ax_c >>> 2;
	assign qh_c   = {{15{q100_s3[11]}}, q100_s3};
	assign qf_c   = qh_c >>> 2;
	assign ys4_c  = mode_s3 ? (a365_c + q4_c - 27'sd2) : (a365_c + q4_c - qh_c + qf_c);

	always_comb begin
		logic       by4, by100, by400;
		logic [7:0] s100;
		logic [9:0] s400;
		for (int j = 0; j < 3; j++) begin
			by4   = (2'(a_s3[1:0] + 2'(j)) == 2'd0);
			s100  = 8'(r100_s3) + 8'(j);
			s400  = 10'(r400_s3) + 10'(j);
			by100 = (s100 == 8'd0) || (s100 == 8'd100);
			by400 = (s400 == 10'd0) || (s400 == 10'd400);
			leap4_c[j] = mode_s3 ? by4 : (by4 && (!by100 || by400));
		end
	end

	func_t              func_s4;
	logic signed [4:0]  month_s4;
	logic signed [5:0]  day_s4;
	logic signed [24:0] dn_s4;
	logic signed [16:0] yr_s4;
	logic signed [26:0] ys_s4;
	logic [2:0]         leap_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			func_s4  <= func_s3;
			month_s4 <= month_s3;
			day_s4   <= day_s3;
			dn_s4    <= dn_s3;
			yr_s4    <= 17'(a_s3 + 18'sd1);
			ys_s4    <= ys4_c;
			leap_s4  <= leap4_c;
		end
	end

	// Stage 5: year correction for day numbers, date checks and sum for dates.
	logic signed [26:0] dnx_c, diff_c, ysel_c, n0_c;
	logic [8:0]         len_m1_c, len_0_c, off_c, doy0_c;
	logic signed [16:0] ysel_yr_c;
	logic               lsel_c;
	logic signed [5:0]  mn_c;
	logic [3:0]         midx_c;
	logic [4:0]         mlen_c;
	logic signed [6:0]  dd_c;
	logic               ybad_in_c, ybad_sel_c, mbad_c, dbad_c;
	err_t               err5_c;

	assign dnx_c    = {{2{dn_s4[24]}}, dn_s4};
	assign diff_c   = dnx_c - ys_s4;
	assign len_m1_c = 9'd365 + 9'(leap_s4[0]);
	assign len_0_c  = 9'd365 + 9'(leap_s4[1]);

	always_comb begin
		if (ys_s4 >= dnx_c) begin
			ysel_yr_c = yr_s4 - 17'sd1;
			ysel_c    = ys_s4 - $signed({18'b0, len_m1_c});
			lsel_c    = leap_s4[0];
		end else if (diff_c > $signed({18'b0, len_0_c})) begin
			ysel_yr_c = yr_s4 + 17'sd1;
			ysel_c    = ys_s4 + $signed({18'b0, len_0_c});
			lsel_c    = leap_s4[2];
		end else begin
			ysel_yr_c = yr_s4;
			ysel_c    = ys_s4;
			lsel_c    = leap_s4[1];
		end
	end

	assign off_c      = 9'(dnx_c - ysel_c);
	assign ybad_sel_c = (ysel_yr_c > YEAR_HI) || (ysel_yr_c < YEAR_LO);
	assign ybad_in_c  = (yr_s4 > YEAR_HI) || (yr_s4 < YEAR_LO);

	// Count back from the year end or the month end, then range check.
	assign mn_c   = month_s4[4] ? ({month_s4[4], month_s4} + 6'sd13) : {month_s4[4], month_s4};
	assign mbad_c = (mn_c < 6'sd1) || (mn_c > 6'sd12);
	assign midx_c = 4'(mn_c - 6'sd1);
	assign mlen_c = month_len(leap_s4[1], midx_c);
	assign dd_c   = day_s4[5] ? ({day_s4[5], day_s4} + $signed({2'b0, mlen_c}) + 7'sd1)
	                          : {day_s4[5], day_s4};
	assign dbad_c = (dd_c < 7'sd1) || (dd_c > $signed({2'b0, mlen_c}));
	assign doy0_c = 9'(dd_c) + cum_days(leap_s4[1], midx_c);
	assign n0_c   = ys_s4 + $signed({18'b0, doy0_c});

	always_comb begin
		case (func_s4)
			FUNC_DATE_TO_NUM, FUNC_ISO_WEEK: begin
				if (ybad_in_c)   err5_c = ERR_YEAR;
				else if (mbad_c) err5_c = ERR_MONTH;
				else if (dbad_c) err5_c = ERR_DAY;
				else             err5_c = ERR_NONE;
			end
			FUNC_NUM_TO_DATE: err5_c = ybad_sel_c ? ERR_YEAR : ERR_NONE;
			default:          err5_c = ERR_NONE;
		endcase
	end

	func_t              func_s5;
	err_t               err_s5;
	logic signed [26:0] n_s5;
	logic [8:0]         doy_s5;
	logic signed [16:0] yr_s5;
	logic               leap_s5;
	logic               leap_prev_s5;
	logic [4:0]         dd_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			func_s5      <= func_s4;
			err_s5       <= err5_c;
			n_s5         <= (func_s4 == FUNC_NUM_TO_DATE) ? dnx_c : n0_c;
			doy_s5       <= (func_s4 == FUNC_NUM_TO_DATE) ? off_c : doy0_c;
			yr_s5        <= ysel_yr_c;
			leap_s5      <= lsel_c;
			leap_prev_s5 <= leap_s4[0];
			dd_s5        <= 5'(dd_c);
		end
	end

	// Stage 6: month and day from the day of year; start the mod-7 product.
	logic [3:0]  mon6_c;
	logic [4:0]  day6_c;
	logic [25:0] v7_c;
	logic [55:0] p7_c;

	cdnc_month_find u_month_find (
		.yday  (doy_s5),
		.leap  (leap_s5),
		.month (mon6_c),
		.day   (day6_c)
	);

	assign v7_c = 26'($unsigned(n_s5 + 27'sd29360127));
	assign p7_c = 56'(v7_c) * 56'd613566757;

	func_t              func_s6;
	err_t               err_s6;
	logic signed [26:0] n_s6;
	logic [8:0]         doy_s6;
	logic signed [16:0] yr_s6;
	logic               leap_prev_s6;
	logic [4:0]         dd_s6;
	logic [3:0]         mon_s6;
	logic [4:0]         day_s6;
	logic [25:0]        v7_s6;
	logic [55:0]        p7_s6;

	always_ff @(posedge clk) begin
		if (en6) begin
			func_s6      <= func_s5;
			err_s6       <= err_s5;
			n_s6         <= n_s5;
			doy_s6       <= doy_s5;
			yr_s6        <= yr_s5;
			leap_prev_s6 <= leap_prev_s5;
			dd_s6        <= dd_s5;
			mon_s6       <= mon6_c;
			day_s6       <= day6_c;
			v7_s6        <= v7_c;
			p7_s6        <= p7_c;
		end
	end

	// Stage 7: weekday is the remainder of the biased day number by seven.
	logic [23:0] q7_c;
	logic [2:0]  wd7_c;

	assign q7_c  = p7_s6[55:32];
	assign wd7_c = v7_s6[2:0] - 3'(q7_c[2:0] * 3'd7);

	func_t              func_s7;
	err_t               err_s7;
	logic signed [26:0] n_s7;
	logic [8:0]         doy_s7;
	logic signed [16:0] yr_s7;
	logic               leap_prev_s7;
	logic [4:0]         dd_s7;
	logic [3:0]         mon_s7;
	logic [4:0]         day_s7;
	logic [2:0]         wd_s7;

	always_ff @(posedge clk) begin
		if (en7) begin
			func_s7      <= func_s6;
			err_s7       <= err_s6;
			n_s7         <= n_s6;
			doy_s7       <= doy_s6;
			yr_s7        <= yr_s6;
			leap_prev_s7 <= leap_prev_s6;
			dd_s7        <= dd_s6;
			mon_s7       <= mon_s6;
			day_s7       <= day_s6;
			wd_s7        <= wd7_c;
		end
	end

	// Stage 8: ISO week and final field selection into the output register.
	logic signed [10:0] w_c;
	logic [18:0]        wm_c;
	logic [5:0]         wk0_c;
	logic               late_c;
	logic [5:0]         week_c;

	assign w_c    = $signed({2'b0, doy_s7}) + 11'sd2 - $signed({8'b0, wd_s7});
	assign wm_c   = 19'(w_c[8:0]) * 19'd293;
	assign wk0_c  = wm_c[16:11] + 6'd1;
	assign late_c = (6'(wd_s7) + 6'd31) < (6'(dd_s7) + 6'd3);

	always_comb begin
		if (!w_c[10]) begin
			week_c = ((wk0_c == 6'd53) && late_c) ? 6'd1 : wk0_c;
		end else if ((w_c == -11'sd1) || ((w_c == -11'sd2) && leap_prev_s7)) begin
			week_c = 6'd53;
		end else begin
			week_c = 6'd52;
		end
	end

	logic signed [24:0] dn_s8;
	logic signed [15:0] year_s8;
	logic [3:0]         month_s8;
	logic [4:0]         day_s8;
	logic [8:0]         doy_s8;
	logic [2:0]         wd_s8;
	logic [5:0]         week_s8;
	err_t               err_s8;

	always_ff @(posedge clk) begin
		if (en8) begin
			dn_s8    <= 25'sd0;
			year_s8  <= 16'sd0;
			month_s8 <= 4'd0;
			day_s8   <= 5'd0;
			doy_s8   <= 9'd0;
			wd_s8    <= 3'd0;
			week_s8  <= 6'd0;
			err_s8   <= err_s7;
			if (err_s7 != ERR_NONE) begin
				dn_s8 <= -25'sd1;
			end else begin
				case (func_s7)
					FUNC_DATE_TO_NUM: begin
						dn_s8 <= 25'(n_s7);
						wd_s8 <= wd_s7;
					end
					FUNC_ISO_WEEK: begin
						dn_s8   <= 25'(n_s7);
						wd_s8   <= wd_s7;
						week_s8 <= week_c;
					end
					FUNC_NUM_TO_DATE: begin
						year_s8  <= 16'(yr_s7);
						month_s8 <= mon_s7;
						day_s8   <= day_s7;
						doy_s8   <= doy_s7;
						wd_s8    <= wd_s7;
					end
					default: begin
						dn_s8 <= 25'sd0;
					end
				endcase
			end
		end
	end

	assign out_valid       = valid_s8;
	assign day_number_out  = dn_s8;
	assign year_out        = year_s8;
	assign month_out       = month_s8;
	assign day_out         = day_s8;
	assign day_of_year_out = doy_s8;
	assign weekday_out     = wd_s8;
	assign iso_week_out    = week_s8;
	assign error_code      = err_s8;

`ifndef SYNTH
	// Input backpressure only appears with the first stage occupied.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled while the first stage is empty");

	// An error result carries an all-ones day number.
	a_err_dn: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (error_code != ERR_NONE)) |-> (&day_number_out))
		else $error("error result without all-ones day number");

	// Weekday stays within Monday to Sunday.
	a_weekday: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (weekday_out <= 3'd6))
		else $error("weekday out of range");

	// A week number only comes with a good result and stays below 54.
	a_week: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (iso_week_out != 6'd0)) |->
		((error_code == ERR_NONE) && (iso_week_out <= 6'd53)))
		else $error("bad ISO week result");
`endif

endmodule

### verif/calendar_day_number_checker.sv
module calendar_day_number_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [1:0]         func,
	input  logic signed [15:0] year_in,
	input  logic signed [4:0]  month_in,
	input  logic signed [5:0]  day_in,
	input  logic signed [24:0] day_number_in,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [24:0] day_number_out,
	input  logic signed [15:0] year_out,
	input  logic [3:0]         month_out,
	input  logic [4:0]         day_out,
	input  logic [8:0]         day_of_year_out,
	input  logic [2:0]         weekday_out,
	input  logic [5:0]         iso_week_out,
	input  logic [1:0]         error_code,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic               cfg_data,
	output int                 fail_count,
	output int                 pending_count
);
	import cdnc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [24:0] day_number;
		logic signed [15:0] year;
		logic [3:0]         month;
		logic [4:0]         day;
		logic [8:0]         yday;
		logic [2:0]         weekday;
		logic [5:0]         iso_week;
		err_t               err;
	} calendar_result_t;

	calendar_result_t expected_dates[$];
	logic julian_mode;

	// Month tables: cumulative days and lengths, common and leap year.
	function automatic longint days_before_month(input bit leap, input int m);
		int common_cum[13] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};
		return common_cum[m] + ((leap && m >= 2) ? 1 : 0);
	endfunction

	function automatic longint month_days(input bit leap, input int m);
		int lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		return (m == 1 && leap) ? 29 : lens[m];
	endfunction

	function automatic longint fdiv(input longint a, input longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0)
			q--;
		return q;
	endfunction

	function automatic bit leap_year(input longint y, input bit jul);
		if (jul)
			return (y % 4) == 0;
		return (y % 4) == 0 && ((y % 100) != 0 || (y % 400) == 0);
	endfunction

	// Day number of the last day of the previous year.
	function automatic longint last_day_before(input longint y, input bit jul);
		longint p;
		p = y - 1;
		if (jul)
			return p * 365 + fdiv(p, 4) - 2;
		return p * 365 + fdiv(p, 4) - fdiv(p, 100) + fdiv(p, 400);
	endfunction

	function automatic int weekday_of(input longint n);
		longint r;
		r = (n - 1) % 7;
		if (r < 0)
			r += 7;
		return int'(r);
	endfunction

	// Predicts the converter's result for one request.
	function automatic calendar_result_t convert_date(input logic [1:0] f,
			input longint y, input longint m, input longint d, input longint dn,
			input bit jul);
		calendar_result_t r;
		err_t ecode;
		bit lp;
		longint n, w, mag, yy, off, ys;
		int wd, mm;
		r = '0;
		r.err = ERR_NONE;
		if (f == FUNC_DATE_TO_NUM || f == FUNC_ISO_WEEK) begin
			if (y > MAX_YEAR || y < -MAX_YEAR) begin
				r.err = ERR_YEAR;
			end else begin
				lp = leap_year(y, jul);
				if (m < 0)
					m += 13;
				if (m < 1 || m > 12) begin
					r.err = ERR_MONTH;
				end else begin
					if (d < 0)
						d += month_days(lp, m - 1) + 1;
					if (d < 1 || d > month_days(lp, m - 1)) begin
						r.err = ERR_DAY;
					end else begin
						n = d + days_before_month(lp, m - 1) + last_day_before(y, jul);
						wd = weekday_of(n);
						r.day_number = 25'(n);
						r.weekday = 3'(wd);
						if (f == FUNC_ISO_WEEK) begin
							w = (n - last_day_before(y, jul) - 1) - wd + 3;
							if (w >= 0) begin
								w = w / 7 + 1;
								if (w == 53 && 31 - d + wd < 3)
									w = 1;
							end else if (w > -2 || (w == -2 && leap_year(y - 1, jul))) begin
								w = 53;
							end else begin
								w = 52;
							end
							r.iso_week = 6'(w);
						end
					end
				end
			end
		end else if (f == FUNC_NUM_TO_DATE) begin
			mag = dn < 0 ? -dn : dn;
			yy = (mag * (jul ? 64'd11758980 : 64'd11759221)) >>> 32;
			if (dn < 0)
				yy = -yy;
			if (dn > 0)
				yy++;
			off = 0;
			lp = 0;
			for (int it = 0; it < 8; it++) begin
				ys = last_day_before(yy, jul);
				if (ys >= dn) begin
					yy--;
					continue;
				end
				lp = leap_year(yy, jul);
				off = dn - ys;
				if (off > days_before_month(lp, 12)) begin
					yy++;
					continue;
				end
				break;
			end
			if (yy > MAX_YEAR || yy < -MAX_YEAR) begin
				r.err = ERR_YEAR;
			end else begin
				mm = 1;
				while (mm < 12 && days_before_month(lp, mm) < off)
					mm++;
				r.year = 16'(yy);
				r.month = 4'(mm);
				r.day = 5'(off - days_before_month(lp, mm - 1));
				r.yday = 9'(off);
				r.weekday = 3'(weekday_of(dn));
			end
		end
		if (r.err != ERR_NONE) begin
			ecode = r.err;
			r = '0;
			r.day_number = -25'sd1;
			r.err = ecode;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	assign pending_count = expected_dates.size();

	// Track the mode, predict accepted requests and compare results.
	always @(posedge clk or negedge arst_n) begin
		calendar_result_t e, r;
		if (!arst_n) begin
			julian_mode = 1'b0;
			fail_count = 0;
			expected_dates.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_dates.size() == 0) begin
					report_mismatch("unexpected result", 0, 0);
				end else begin
					e = expected_dates.pop_front();
					if (day_number_out !== e.day_number)
						report_mismatch("day_number", day_number_out, e.day_number);
					if (year_out !== e.year)
						report_mismatch("year", year_out, e.year);
					if (month_out !== e.month)
						report_mismatch("month", month_out, e.month);
					if (day_out !== e.day)
						report_mismatch("day", day_out, e.day);
					if (day_of_year_out !== e.yday)
						report_mismatch("day of year", day_of_year_out, e.yday);
					if (weekday_out !== e.weekday)
						report_mismatch("weekday", weekday_out, e.weekday);
					if (iso_week_out !== e.iso_week)
						report_mismatch("iso_week", iso_week_out, e.iso_week);
					if (error_code !== e.err)
						report_mismatch("error_code", error_code, e.err);
				end
			end
			if (in_valid && !in_stall) begin
				r = convert_date(func, year_in, month_in, day_in, day_number_in, julian_mode);
				expected_dates.push_back(r);
			end
			if (cfg_valid && cfg_ready)
				julian_mode = cfg_data;
		end
	end
endmodule

### verif/tb_calendar_day_number_converter.sv
module tb_calendar_day_number_converter;
	import cdnc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_REQUESTS = 1830;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [1:0] func;
	logic signed [15:0] year_in;
	logic signed [4:0] month_in;
	logic signed [5:0] day_in;
	logic signed [24:0] day_number_in;
	logic signed [24:0] day_number_out;
	logic signed [15:0] year_out;
	logic [3:0] month_out;
	logic [4:0] day_out;
	logic [8:0] day_of_year_out;
	logic [2:0] weekday_out;
	logic [5:0] iso_week_out;
	logic [1:0] error_code;
	logic cfg_valid, cfg_ready, cfg_data;
	int fail_count, pending_count;
	longint cycle_count;
	bit long_hold;
	bit stall_free;

	calendar_day_number_converter i_dut (.*);

	calendar_day_number_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver stalls on its own pattern, with one long hold-off on request.
	initial begin
		int hold;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				hold = 0;
				while (hold < 60) begin
					@(posedge clk);
					hold++;
				end
				out_stall <= 1'b0;
				long_hold = 0;
			end else if (stall_free) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 3) == 0);
			end
		end
	end

	// Timeout watchdog.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	task automatic send_request(input logic [1:0] f, input logic signed [15:0] y,
			input logic signed [4:0] m, input logic signed [5:0] d,
			input logic signed [24:0] dn);
		in_valid <= 1'b1;
		func <= f;
		year_in <= y;
		month_in <= m;
		day_in <= d;
		day_number_in <= dn;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// One edge first so that the last accepted request is already queued.
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_mode(input logic jul);
		cfg_valid <= 1'b1;
		cfg_data <= jul;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Mostly valid dates; sometimes wide noise on every field.
	task automatic random_request();
		logic [1:0] f;
		logic signed [15:0] y;
		logic signed [4:0] m;
		logic signed [5:0] d;
		logic signed [24:0] dn;
		f = 2'($urandom_range(0, 3));
		y = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 6000)) - 16'sd3000;
		m = $urandom_range(0, 7) == 0 ? 5'($urandom) :
			($urandom_range(0, 1) ? 5'($urandom_range(1, 12)) : -5'($urandom_range(1, 12)));
		d = $urandom_range(0, 7) == 0 ? 6'($urandom) :
			($urandom_range(0, 1) ? 6'($urandom_range(1, 28)) : -6'($urandom_range(1, 28)));
		case ($urandom_range(0, 3))
			0: dn = 25'($urandom);
			1: dn = 25'($urandom_range(0, 24000000)) - 25'sd12000000;
			default: dn = 25'($urandom_range(0, 2000000)) - 25'sd1000000;
		endcase
		send_request(f, y, m, d, dn);
	endtask

	// Stimulus: directed corners in both calendars, then bursty random requests.
	initial begin
		int burst, gap;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_DATE_TO_NUM;
		year_in = '0;
		month_in = '0;
		day_in = '0;
		day_number_in = '0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		long_hold = 0;
		stall_free = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int mode = 0; mode < 2; mode++) begin
			write_mode(mode[0]);
			send_request(FUNC_DATE_TO_NUM, 16'sd1, 5'sd1, 6'sd1, 25'sd0);
			send_request(FUNC_DATE_TO_NUM, 16'sd2000, -5'sd11, -6'sd1, 25'sd0);
			send_request(FUNC_DATE_TO_NUM, 16'sd32767, -5'sd1, -6'sd1, 25'sd0);
			send_request(FUNC_DATE_TO_NUM, -16'sd32767, 5'sd1, 6'sd1, 25'sd0);
			send_request(FUNC_DATE_TO_NUM, -16'sd32768, 5'sd1, 6'sd1, 25'sd0);
			send_request(FUNC_DATE_TO_NUM, 16'sd2001, 5'sd13, 6'sd1, 25'sd0);
			send_request(FUNC_DATE_TO_NUM, 16'sd2001, -5'sd16, 6'sd1, 25'sd0);
			send_request(FUNC_DATE_TO_NUM, 16'sd1900, 5'sd2, 6'sd29, 25'sd0);
			send_request(FUNC_DATE_TO_NUM, 16'sd1900, 5'sd2, -6'sd32, 25'sd0);
			send_request(FUNC_DATE_TO_NUM, 16'sd5, 5'sd0, 6'sd0, 25'sd0);
			send_request(FUNC_NUM_TO_DATE, 16'sd0, 5'sd0, 6'sd0, 25'sd0);
			send_request(FUNC_NUM_TO_DATE, 16'sd0, 5'sd0, 6'sd0, 25'sd1);
			send_request(FUNC_NUM_TO_DATE, 16'sd0, 5'sd0, 6'sd0, 25'sd16777215);
			send_request(FUNC_NUM_TO_DATE, 16'sd0, 5'sd0, 6'sd0, -25'sd16777216);
			send_request(FUNC_NUM_TO_DATE, 16'sd0, 5'sd0, 6'sd0, 25'sd11967900);
			send_request(FUNC_ISO_WEEK, 16'sd2004, 5'sd12, 6'sd31, 25'sd0);
			send_request(FUNC_ISO_WEEK, 16'sd2008, 5'sd12, 6'sd29, 25'sd0);
			send_request(FUNC_ISO_WEEK, 16'sd2010, 5'sd1, 6'sd1, 25'sd0);
			send_request(FUNC_ISO_WEEK, 16'sd2005, 5'sd1, 6'sd1, 25'sd0);
			send_request(FUNC_NONE, -16'sd1, -5'sd1, -6'sd1, -25'sd1);
			drain_pipeline();
		end
		write_mode(1'b0);
		// Hold the output while the sender keeps offering requests.
		long_hold = 1;
		repeat (40) random_request();
		drain_pipeline();
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			if (i == RANDOM_REQUESTS / 2) begin
				drain_pipeline();
				write_mode(1'b1);
			end
			stall_free = (i > 1400 && i < 1550);
			random_request();
			burst = $urandom_range(0, 3);
			if (burst == 0 && !stall_free) begin
				in_valid <= 1'b0;
				gap = $urandom_range(1, 5);
				repeat (gap) @(posedge clk);
			end
		end
		drain_pipeline();
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

### files.f
rtl/core/cdnc_pkg.sv
rtl/core/cdnc_month_find.sv
rtl/core/calendar_day_number_converter.sv
verif/calendar_day_number_checker.sv
verif/tb_calendar_day_number_converter.sv
